// ===== rtl/tlf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and codes for the translation buffer and its cells.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int PID_W    = 16;
  localparam int SEG_W    = 8;
  localparam int PAGE_W   = 16;
  localparam int FRAME_W  = 16;
  localparam int LIMIT_W  = 5;
  localparam int OUTC_W   = 3;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

  typedef enum logic [OUTC_W-1:0] {
    OUT_MISS     = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_REPLACED = 3'd2,
    OUT_APPENDED = 3'd3,
    OUT_EVICTED  = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [SEG_W-1:0]   segment;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic match_en;
    logic apply;
    logic update;
    logic lru;
    logic hit;
    logic append;
  } cell_ctrl_t;

  typedef struct packed {
    logic in_use;
    logic is_last;
    logic below_last;
    logic is_fill;
  } cell_pos_t;

endpackage

// ===== rtl/tlf_cell.sv =====
// ----------------------------------------------------------------------------
// tlf_cell
// One buffer entry: key compare, first-match chain link and entry update.
// ----------------------------------------------------------------------------
module tlf_cell import tlf_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  cell_pos_t  pos,
  input  entry_t     item,
  input  entry_t     right,
  input  entry_t     sel,
  input  logic       hit_before,
  output logic       hit_through,
  output logic       first,
  output entry_t     entry
);

  logic   match_q;
  logic   match_next;
  entry_t entry_next;

  always_comb begin
    if (ctrl.update) begin
      match_next = pos.in_use && (entry.frame == item.frame);
    end else begin
      match_next = pos.in_use && (entry.pid == item.pid) &&
                   (entry.segment == item.segment) && (entry.page == item.page);
    end
  end

  assign first       = match_q && !hit_before;
  assign hit_through = hit_before || match_q;

  always_comb begin
    entry_next = entry;
    if (ctrl.apply) begin
      if (!ctrl.update) begin
        if (ctrl.lru && ctrl.hit) begin
          if (pos.is_last) begin
            entry_next = sel;
          end else if (pos.below_last && hit_through) begin
            entry_next = right;
          end
        end
      end else if (ctrl.hit) begin
        if (first) begin
          entry_next = item;
        end
      end else if (ctrl.append) begin
        if (pos.is_fill) begin
          entry_next = item;
        end
      end else begin
        if (pos.is_last) begin
          entry_next = item;
        end else if (pos.below_last) begin
          entry_next = right;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.match_en) begin
      match_q <= match_next;
    end
    entry <= entry_next;
  end

endmodule

// ===== rtl/tlb_lookup_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_lru
// Ordered translation buffer with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// The buffer is a row of cells ordered oldest to newest. An item is
// registered on acceptance, every cell compares its entry in ST_MATCH, and in
// ST_APPLY the first-match chain runs along the cells, which then hold, load
// the item, take their right neighbour or take the hit entry; ST_APPLY waits
// while a stalled result still fills the output register. A new item is taken
// only in ST_IDLE, once the last one is through; it may be taken while a
// finished result still waits in the output register. An entry is only valid
// below the fill count, so no clearing pass follows reset.
module tlb_lookup_fifo_lru import tlf_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [PID_W-1:0]     pid,
  input  logic [SEG_W-1:0]     segment,
  input  logic [PAGE_W-1:0]    page,
  input  logic [FRAME_W-1:0]   frame,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUTC_W-1:0]    outcome,
  output logic [FRAME_W-1:0]   frame_out
);

  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

  state_t state;
  state_t state_next;

  logic               replacement_mode;
  logic [LIMIT_W-1:0] entry_limit;
  logic [FILL_W-1:0]  fill_count;
  logic               op;
  entry_t             item;

  logic               accept;
  logic               match_en;
  logic               apply_go;
  logic [LIM_W-1:0]   limit_ext;
  logic [LIM_W-1:0]   active_limit;
  logic               append;
  logic               hit;
  cell_ctrl_t         ctrl;
  entry_t             sel;
  outcome_t           outcome_next;

  logic   [MAX_ENTRIES:0]   chain;
  logic   [MAX_ENTRIES-1:0] first;
  entry_t                   cell_entry [MAX_ENTRIES];
  cell_pos_t                cell_pos   [MAX_ENTRIES];

  always_comb begin
    unique case (state)
      ST_IDLE:  state_next = in_valid ? ST_MATCH : ST_IDLE;
      ST_MATCH: state_next = ST_APPLY;
      ST_APPLY: state_next = apply_go ? ST_IDLE : ST_APPLY;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    match_en = (state == ST_MATCH);
    apply_go = (state == ST_APPLY) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_mode <= MODE_FIFO;
      entry_limit      <= LIMIT_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:  replacement_mode <= cfg_data[0];
        REG_LIMIT: entry_limit      <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op           <= operation;
      item.pid     <= pid;
      item.segment <= segment;
      item.page    <= page;
      item.frame   <= frame;
    end
  end

  assign limit_ext = LIM_W'(entry_limit);

  always_comb begin
    priority if (limit_ext == '0) begin
      active_limit = LIM_W'(1);
    end else if (limit_ext > LIM_W'(MAX_ENTRIES)) begin
      active_limit = LIM_W'(MAX_ENTRIES);
    end else begin
      active_limit = limit_ext;
    end
  end

  assign hit    = chain[MAX_ENTRIES];
  assign append = (LIM_W'(fill_count) < active_limit);

  always_comb begin
    ctrl.match_en = match_en;
    ctrl.apply    = apply_go;
    ctrl.update   = (op == OP_UPDATE);
    ctrl.lru      = (replacement_mode == MODE_LRU);
    ctrl.hit      = hit;
    ctrl.append   = append;
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    always_comb begin
      cell_pos[i].in_use     = (fill_count > FILL_W'(i));
      cell_pos[i].is_last    = (fill_count == FILL_W'(i + 1));
      cell_pos[i].below_last = (fill_count > FILL_W'(i + 1));
      cell_pos[i].is_fill    = (fill_count == FILL_W'(i));
    end

    tlf_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (cell_pos[i]),
      .item        (item),
      .right       ((i == MAX_ENTRIES - 1) ? sel : cell_entry[(i + 1) % MAX_ENTRIES]),
      .sel         (sel),
      .hit_before  (chain[i]),
      .hit_through (chain[i + 1]),
      .first       (first[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel = sel | (first[i] ? cell_entry[i] : entry_t'('0));
    end
  end

  always_comb begin
    if (op == OP_LOOKUP) begin
      outcome_next = hit ? OUT_HIT : OUT_MISS;
    end else if (hit) begin
      outcome_next = OUT_REPLACED;
    end else begin
      outcome_next = append ? OUT_APPENDED : OUT_EVICTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (apply_go && (op == OP_UPDATE) && !hit && append) begin
      fill_count <= fill_count + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      outcome   <= outcome_next;
      frame_out <= ((op == OP_LOOKUP) && hit) ? sel.frame : '0;
    end
  end

endmodule

// ===== rtl/tlf_checker.sv =====
// ----------------------------------------------------------------------------
// tlf_checker
// Port-level checks for the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tlf_checker import tlf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OUTC_W-1:0]    outcome,
  input logic [FRAME_W-1:0]   frame_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(frame_out))
    else $error("stalled result changed");

  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome != OUT_HIT) |-> frame_out == '0)
    else $error("frame given without a hit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while one is in flight");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without an item three cycles before");

endmodule

bind tlb_lookup_fifo_lru tlf_checker u_tlf_checker (.*);
